[design/pfl_pkg.sv]
`timescale 1ns / 1ps

package pfl_pkg;

    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;
    localparam logic [1:0] ACT_STOP  = 2'd3;

    localparam logic [7:0]  SYNC_BYTE      = 8'hFF;
    localparam logic [7:0]  PAN_REPLY_CMD  = 8'h59;
    localparam logic [15:0] FULL_TURN      = 16'd36000;
    localparam logic [15:0] THRESH_RESET   = 16'd30000;
    localparam int          WIN_DEPTH      = 6;
    localparam logic [2:0]  WIN_FULL       = 3'd6;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] byte_value;
    } in_word_t;

    typedef struct packed {
        logic [15:0] angle;
        logic        lap_valid;
        logic [31:0] lap_ticks;
    } out_word_t;

    // One queued event: a tick, a lap start or stop, or a pan reply frame.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] pan;
    } event_t;

endpackage

[design/pfl_front.sv]
`timescale 1ns / 1ps

module pfl_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pfl_pkg::in_word_t in_data,
    input  logic              q_full,
    output logic              q_push,
    output pfl_pkg::event_t   q_entry
);

    logic [7:0] win_reg  [pfl_pkg::WIN_DEPTH];
    logic [7:0] win_next [pfl_pkg::WIN_DEPTH];
    logic [2:0] fill_reg;
    logic [2:0] fill_next;
    logic       accept;
    logic       is_byte;
    logic       window_full;
    logic [7:0] sum;
    logic       frame_ok;

    assign in_ready    = !q_full;
    assign accept      = in_valid && !q_full;
    assign is_byte     = in_data.action == pfl_pkg::ACT_BYTE;
    assign window_full = fill_reg == pfl_pkg::WIN_FULL;

    // Checksum over bytes 1..5; the incoming byte is the checksum byte.
    assign sum = win_reg[1] + win_reg[2] + win_reg[3] + win_reg[4] + win_reg[5];
    assign frame_ok = win_reg[0] == pfl_pkg::SYNC_BYTE && sum == in_data.byte_value;

    assign q_push = accept && (!is_byte || (window_full && frame_ok
                    && win_reg[3] == pfl_pkg::PAN_REPLY_CMD));
    assign q_entry.kind = in_data.action;
    assign q_entry.pan  = {win_reg[4], win_reg[5]};

    always_comb
    begin
        win_next  = win_reg;
        fill_next = fill_reg;
        if (accept && is_byte)
        begin
            if (!window_full)
            begin
                for (int i = 0; i < pfl_pkg::WIN_DEPTH; i++)
                begin
                    if (fill_reg == 3'(i))
                    begin
                        win_next[i] = in_data.byte_value;
                    end
                end
                fill_next = fill_reg + 3'd1;
            end
            else if (frame_ok)
            begin
                fill_next = '0;
            end
            else
            begin
                // drop the oldest byte, keep six
                for (int i = 0; i < pfl_pkg::WIN_DEPTH - 1; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[pfl_pkg::WIN_DEPTH - 1] = in_data.byte_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

[design/pfl_queue.sv]
`timescale 1ns / 1ps

module pfl_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pfl_pkg::event_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output pfl_pkg::event_t head
);

    pfl_pkg::event_t              mem_reg [pfl_pkg::QUEUE_DEPTH];
    logic [pfl_pkg::QUEUE_AW-1:0] wr_reg;
    logic [pfl_pkg::QUEUE_AW-1:0] wr_next;
    logic [pfl_pkg::QUEUE_AW-1:0] rd_reg;
    logic [pfl_pkg::QUEUE_AW-1:0] rd_next;
    logic [pfl_pkg::QUEUE_CW-1:0] count_reg;
    logic [pfl_pkg::QUEUE_CW-1:0] count_next;

    assign full  = count_reg == pfl_pkg::QUEUE_CW'(pfl_pkg::QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem_reg[rd_reg];

    always_comb
    begin
        wr_next    = push ? wr_reg + 1'b1 : wr_reg;
        rd_next    = pop ? rd_reg + 1'b1 : rd_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_entry;
        end
    end

endmodule

[design/pfl_back.sv]
`timescale 1ns / 1ps

module pfl_back
#(
    parameter int TICK_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  pfl_pkg::event_t    q_head,
    output logic               q_pop,
    input  logic [15:0]        threshold,
    output logic               out_valid,
    input  logic               out_ready,
    output pfl_pkg::out_word_t out_data
);

    logic [TICK_WIDTH-1:0] tick_reg;
    logic [TICK_WIDTH-1:0] tick_next;
    logic [TICK_WIDTH-1:0] cross_reg;
    logic [TICK_WIDTH-1:0] cross_next;
    logic [TICK_WIDTH-1:0] lap_full;
    logic [15:0]           prev_angle_reg;
    logic [15:0]           prev_angle_next;
    logic                  prev_valid_reg;
    logic                  prev_valid_next;
    logic                  running_reg;
    logic                  running_next;
    logic                  start_valid_reg;
    logic                  start_valid_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    pfl_pkg::out_word_t    out_data_reg;
    pfl_pkg::out_word_t    out_data_next;
    logic [15:0]           angle;
    logic [15:0]           diff;
    logic                  jump;
    logic                  is_frame;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign q_pop     = !q_empty && (!out_valid_reg || out_ready);
    assign is_frame  = q_head.kind == pfl_pkg::ACT_BYTE;

    // pan is below twice a full turn, so one subtract does the modulo
    assign angle = q_head.pan >= pfl_pkg::FULL_TURN ? q_head.pan - pfl_pkg::FULL_TURN
                                                    : q_head.pan;
    assign diff  = angle >= prev_angle_reg ? angle - prev_angle_reg
                                           : prev_angle_reg - angle;
    assign jump     = prev_valid_reg && running_reg && diff > threshold;
    assign lap_full = tick_reg - cross_reg;

    always_comb
    begin
        tick_next        = tick_reg;
        cross_next       = cross_reg;
        prev_angle_next  = prev_angle_reg;
        prev_valid_next  = prev_valid_reg;
        running_next     = running_reg;
        start_valid_next = start_valid_reg;
        out_data_next    = out_data_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        if (q_pop)
        begin
            case (q_head.kind)
                pfl_pkg::ACT_TICK:
                begin
                    tick_next = tick_reg + 1'b1;
                end
                pfl_pkg::ACT_START:
                begin
                    running_next     = 1'b1;
                    start_valid_next = 1'b0;
                end
                pfl_pkg::ACT_STOP:
                begin
                    running_next = 1'b0;
                end
                default:
                begin
                    if (jump)
                    begin
                        cross_next       = tick_reg;
                        start_valid_next = 1'b1;
                    end
                    prev_angle_next          = angle;
                    prev_valid_next          = 1'b1;
                    out_data_next.angle      = angle;
                    out_data_next.lap_valid  = jump && start_valid_reg;
                    out_data_next.lap_ticks  = (jump && start_valid_reg) ? 32'(lap_full)
                                                                         : 32'd0;
                    out_valid_next           = is_frame;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg        <= '0;
            cross_reg       <= '0;
            prev_angle_reg  <= '0;
            prev_valid_reg  <= 1'b0;
            running_reg     <= 1'b0;
            start_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            tick_reg        <= tick_next;
            cross_reg       <= cross_next;
            prev_angle_reg  <= prev_angle_next;
            prev_valid_reg  <= prev_valid_next;
            running_reg     <= running_next;
            start_valid_reg <= start_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

[design/pan_frame_parser_lap_timer.sv]
`timescale 1ns / 1ps

// Pan frame parser with lap timer. Every word (serial byte, tick, lap start,
// lap stop) is taken back to back while the four-entry event queue between
// the frame parser and the lap timer has room; the parser checks sync and the
// five-byte checksum in the cycle a byte arrives. A pan reply (command 0x59)
// is queued with its checksum byte and raises out_valid once the lap timer pops
// it; other words give no result. The lap timer drains one event per cycle
// while the output register is free or being taken, so a stalled output backs
// up the queue and then in_ready drops. The jump threshold resets to 30000 and
// is written through cfg_*; the user must do this only while idle, unenforced.
module pan_frame_parser_lap_timer
#(
    parameter int TICK_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pfl_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output pfl_pkg::out_word_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data
);

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    pfl_pkg::event_t q_entry;
    pfl_pkg::event_t q_head;
    logic [15:0]     threshold_reg;
    logic [15:0]     threshold_next;

    assign cfg_ready      = 1'b1;
    assign threshold_next = (cfg_valid && cfg_ready) ? cfg_data : threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= pfl_pkg::THRESH_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

    pfl_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    pfl_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (q_head)
    );

    pfl_back #(.TICK_WIDTH(TICK_WIDTH)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .threshold (threshold_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_full))
        else $error("event pushed into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("event popped from an empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(q_pop) && $past(q_head.kind) == pfl_pkg::ACT_BYTE)
        else $error("result raised without a popped pan frame");

endmodule

[tb/tb_pan_frame_parser_lap_timer.sv]
`timescale 1ns / 1ps

module tb_pan_frame_parser_lap_timer;

    localparam int     FRAME_BYTES     = 7;
    localparam int     RANDOM_WORDS    = 950;
    localparam int     SETTLE_CYCLES   = 16;
    localparam int     HOLD_OFF_CYCLES = 400;
    localparam int     HOLD_OFF_AFTER  = 300;
    localparam longint CYCLE_LIMIT     = 400000;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    pfl_pkg::in_word_t  in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    pfl_pkg::out_word_t out_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [15:0]        cfg_data  = '0;

    pan_frame_parser_lap_timer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // parser and lap timer shadow state
    logic [7:0]  win_bytes [FRAME_BYTES];
    int          win_fill;
    logic [15:0] jump_limit;
    logic [15:0] last_angle;
    bit          last_angle_seen;
    bit          lap_on;
    bit          crossing_seen;
    logic [31:0] crossing_tick;
    logic [31:0] tick_now;

    pfl_pkg::out_word_t expected_replies [$];
    pfl_pkg::in_word_t  pending_words [$];
    pfl_pkg::out_word_t want_reply;

    int          words_queued   = 0;
    int          words_accepted = 0;
    int          mismatches     = 0;
    longint      cycles         = 0;
    int          gen_pan        = 0;
    bit          in_taken       = 1'b0;
    int          send_gap       = 0;
    int          send_calm      = 0;
    int          recv_gap       = 0;
    int          recv_calm      = 0;
    int          hold_left      = 0;
    bit          hold_done      = 1'b0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic parse_word(pfl_pkg::in_word_t w);
        logic [7:0]         sum;
        logic [15:0]        pan;
        logic [15:0]        angle;
        logic [15:0]        jump;
        pfl_pkg::out_word_t reply;
        case (w.action)
            pfl_pkg::ACT_TICK:  tick_now = tick_now + 32'd1;
            pfl_pkg::ACT_START:
            begin
                lap_on = 1'b1;
                crossing_seen = 1'b0;
            end
            pfl_pkg::ACT_STOP:  lap_on = 1'b0;
            default:
            begin
                if (win_fill >= FRAME_BYTES)
                    win_fill = 0;
                win_bytes[win_fill] = w.byte_value;
                win_fill++;
                if (win_fill == FRAME_BYTES)
                begin
                    sum = win_bytes[1] + win_bytes[2] + win_bytes[3] + win_bytes[4]
                        + win_bytes[5];
                    if (win_bytes[0] != pfl_pkg::SYNC_BYTE || sum != win_bytes[6])
                    begin
                        // slide past the oldest byte
                        for (int i = 0; i < FRAME_BYTES - 1; i++)
                            win_bytes[i] = win_bytes[i + 1];
                        win_fill = FRAME_BYTES - 1;
                    end
                    else
                    begin
                        win_fill = 0;
                        if (win_bytes[3] == pfl_pkg::PAN_REPLY_CMD)
                        begin
                            pan = {win_bytes[4], win_bytes[5]};
                            angle = (pan >= pfl_pkg::FULL_TURN) ? pan - pfl_pkg::FULL_TURN
                                                                : pan;
                            reply = '0;
                            reply.angle = angle;
                            if (last_angle_seen && lap_on)
                            begin
                                jump = (angle >= last_angle) ? angle - last_angle
                                                             : last_angle - angle;
                                if (jump > jump_limit)
                                begin
                                    if (crossing_seen)
                                    begin
                                        reply.lap_valid = 1'b1;
                                        reply.lap_ticks = tick_now - crossing_tick;
                                    end
                                    crossing_tick = tick_now;
                                    crossing_seen = 1'b1;
                                end
                            end
                            last_angle = angle;
                            last_angle_seen = 1'b1;
                            expected_replies.push_back(reply);
                        end
                    end
                end
            end
        endcase
    endtask

    function automatic int gap_after(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
            calm = $urandom_range(30, 120);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] next_pan();
        int mode;
        int raw;
        mode = $urandom_range(0, 9);
        raw = 0;
        case (mode)
            0, 1, 2, 3: gen_pan = (gen_pan + $urandom_range(0, 800)) % 36000;
            4:          gen_pan = (gen_pan + 36000 - $urandom_range(0, 800)) % 36000;
            5, 6:       gen_pan = $urandom_range(0, 35999);
            7:
            begin
                raw = $urandom_range(0, 65535);
                gen_pan = raw % 36000;
                return raw[15:0];
            end
            8:
            begin
                case ($urandom_range(0, 3))
                    0:       raw = 0;
                    1:       raw = 35999;
                    2:       raw = 36000;
                    default: raw = 65535;
                endcase
                gen_pan = raw % 36000;
                return raw[15:0];
            end
            default:
            begin
                // same angle seen through the fold above a full turn
                if (gen_pan < 29536)
                    return 16'(gen_pan + 36000);
            end
        endcase
        return 16'(gen_pan);
    endfunction

    task automatic queue_word(logic [1:0] act, logic [7:0] value);
        pfl_pkg::in_word_t w;
        w.action = act;
        w.byte_value = value;
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic queue_frame(logic [7:0] cmd, logic [15:0] pan, bit bad_sum);
        logic [7:0] body [5];
        logic [7:0] sum;
        body[0] = 8'($urandom_range(0, 255));
        body[1] = 8'($urandom_range(0, 255));
        body[2] = cmd;
        body[3] = pan[15:8];
        body[4] = pan[7:0];
        sum = body[0] + body[1] + body[2] + body[3] + body[4];
        if (bad_sum)
            sum = sum ^ 8'($urandom_range(1, 255));
        queue_word(pfl_pkg::ACT_BYTE, pfl_pkg::SYNC_BYTE);
        foreach (body[i])
            queue_word(pfl_pkg::ACT_BYTE, body[i]);
        queue_word(pfl_pkg::ACT_BYTE, sum);
    endtask

    task automatic queue_random(int count);
        int         target;
        int         pick;
        logic [7:0] cmd;
        target = words_queued + count;
        while (words_queued < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                queue_frame(pfl_pkg::PAN_REPLY_CMD, next_pan(), 1'b0);
            else if (pick < 63)
            begin
                cmd = 8'($urandom_range(0, 255));
                if (cmd == pfl_pkg::PAN_REPLY_CMD)
                    cmd = 8'h58;
                queue_frame(cmd, 16'($urandom_range(0, 65535)), 1'b0);
            end
            else if (pick < 80)
                repeat ($urandom_range(1, 6))
                    queue_word(pfl_pkg::ACT_TICK, 8'($urandom_range(0, 255)));
            else if (pick < 86)
                queue_word(pfl_pkg::ACT_START, 8'($urandom_range(0, 255)));
            else if (pick < 89)
                queue_word(pfl_pkg::ACT_STOP, 8'($urandom_range(0, 255)));
            else if (pick < 94)
                repeat ($urandom_range(1, 3))
                    queue_word(pfl_pkg::ACT_BYTE, 8'($urandom_range(0, 255)));
            else if (pick < 97)
                queue_frame(pfl_pkg::PAN_REPLY_CMD, next_pan(), 1'b1);
            else
                queue_word(pfl_pkg::ACT_BYTE, pfl_pkg::SYNC_BYTE);
        end
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || in_valid || expected_replies.size() != 0)
            @(posedge clk);
        // let queued ticks and lap events drain
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        jump_limit = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] limits [5];
        jump_limit = pfl_pkg::THRESH_RESET;
        foreach (win_bytes[i])
            win_bytes[i] = '0;
        win_fill = 0;
        last_angle = '0;
        last_angle_seen = 1'b0;
        lap_on = 1'b0;
        crossing_seen = 1'b0;
        crossing_tick = '0;
        tick_now = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset threshold
        queue_frame(pfl_pkg::PAN_REPLY_CMD, 16'h0000, 1'b0);
        queue_word(pfl_pkg::ACT_START, 8'h00);
        queue_frame(pfl_pkg::PAN_REPLY_CMD, 16'hFFFF, 1'b0);
        queue_frame(pfl_pkg::PAN_REPLY_CMD, 16'd35999, 1'b0);
        queue_word(pfl_pkg::ACT_TICK, 8'hFF);
        queue_word(pfl_pkg::ACT_TICK, 8'h00);
        queue_frame(pfl_pkg::PAN_REPLY_CMD, 16'd0, 1'b0);
        queue_word(pfl_pkg::ACT_TICK, 8'hAA);
        queue_frame(pfl_pkg::PAN_REPLY_CMD, 16'd35000, 1'b0);
        queue_frame(8'h00, 16'd12345, 1'b0);
        queue_word(pfl_pkg::ACT_BYTE, 8'h00);
        queue_frame(pfl_pkg::PAN_REPLY_CMD, 16'd36000, 1'b1);
        queue_word(pfl_pkg::ACT_STOP, 8'h55);
        queue_frame(pfl_pkg::PAN_REPLY_CMD, 16'd0, 1'b0);
        queue_word(pfl_pkg::ACT_START, 8'hFF);
        queue_frame(pfl_pkg::PAN_REPLY_CMD, 16'd35999, 1'b0);
        wait_idle();

        limits[0] = 16'd0;
        limits[1] = 16'd35999;
        limits[2] = 16'($urandom_range(1, 34999));
        limits[3] = 16'd18000;
        limits[4] = pfl_pkg::THRESH_RESET;
        foreach (limits[i])
        begin
            write_threshold(limits[i]);
            queue_random(RANDOM_WORDS / 5);
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_replies.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // input driver: hold the word until taken, then pick gap or next word
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            in_taken = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_words.size() != 0)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_words[0];
                send_gap = gap_after(send_calm);
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            parse_word(in_data);
            void'(pending_words.pop_front());
            in_taken = 1'b1;
            words_accepted++;
        end
    end

    // long receiver hold-off so the event queue backs up into in_ready
    always @(negedge clk)
    begin
        if (hold_left > 0)
            hold_left--;
        else if (!hold_done && words_accepted >= HOLD_OFF_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
            out_ready <= 1'b0;
        else if (recv_gap > 0)
        begin
            recv_gap--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            recv_gap = gap_after(recv_calm);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_replies.size() == 0)
                report_mismatch("reply with none pending, angle",
                                longint'(out_data.angle), longint'(0));
            else
            begin
                want_reply = expected_replies.pop_front();
                if (out_data.angle !== want_reply.angle)
                    report_mismatch("angle", longint'(out_data.angle),
                                    longint'(want_reply.angle));
                if (out_data.lap_valid !== want_reply.lap_valid)
                    report_mismatch("lap_valid", longint'(out_data.lap_valid),
                                    longint'(want_reply.lap_valid));
                if (out_data.lap_ticks !== want_reply.lap_ticks)
                    report_mismatch("lap_ticks", longint'(out_data.lap_ticks),
                                    longint'(want_reply.lap_ticks));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

endmodule

[filelist.f]
design/pfl_pkg.sv
design/pfl_front.sv
design/pfl_queue.sv
design/pfl_back.sv
design/pan_frame_parser_lap_timer.sv
tb/tb_pan_frame_parser_lap_timer.sv
